/* src/sensor_relay_and_loop_output_core_assert.svh */
// assertion macros for the transmitter relay and loop output core
// no dependencies; included by the top level only
`ifndef SENSOR_RELAY_AND_LOOP_OUTPUT_CORE_ASSERT_SVH
`define SENSOR_RELAY_AND_LOOP_OUTPUT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SRLO_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srlo assertion failed");
`define SRLO_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srlo assertion failed");
`else
`define SRLO_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define SRLO_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* src/srlo_pkg.sv */
// shared types, constants and helper functions of the relay and loop output core
// no dependencies
`default_nettype none
package srlo_pkg;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int Q_W       = 16;
	localparam int DIFF_W    = 20;
	localparam int PROD_W    = DIFF_W + Q_W;
	localparam int VAL_W     = 21;

	localparam logic [15:0] VOLT_OFFSET  = 16'h1999;
	localparam logic [15:0] VOLT_SPAN    = 16'hCCCC;
	localparam logic [15:0] NAMUR_OFFSET = 16'h2AAA;
	localparam logic [15:0] NAMUR_SPAN   = 16'hAAAA;
	localparam logic [15:0] CODE_FULL    = 16'hFFFF;
	localparam logic [15:0] SHORT_LIMIT  = 16'd100;
	localparam logic [15:0] OPEN_LIMIT   = 16'd50000;
	localparam logic [15:0] RECIP_TEN    = 16'd52429;
	localparam int          RECIP_SHIFT  = 19;

	localparam logic [1:0] MODE_VOLTAGE = 2'd1;
	localparam logic [1:0] MODE_NAMUR   = 2'd2;

	localparam logic [1:0] LED_OFF   = 2'd0;
	localparam logic [1:0] LED_OPEN  = 2'd1;
	localparam logic [1:0] LED_SHORT = 2'd2;
	localparam logic [1:0] LED_FAULT = 2'd3;

	typedef enum logic [CFG_AW-1:0] {
		REG_TEMPERATURE_MODE = 3'd0,
		REG_RELAY_ENABLE     = 3'd1,
		REG_RELAY_OFF_LOW    = 3'd2,
		REG_RELAY_ON_LOW     = 3'd3,
		REG_RELAY_ON_HIGH    = 3'd4,
		REG_RELAY_OFF_HIGH   = 3'd5,
		REG_RANGE_LOW        = 3'd6,
		REG_RANGE_HIGH       = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FULL,
		SEL_SCALED
	} code_sel_t;

	typedef struct packed {
		logic [15:0] resistance;
		logic [15:0] temperature;
		logic        link_fault;
		logic [1:0]  output_mode;
	} in_item_t;

	typedef struct packed {
		logic        relay_on;
		logic        dac_enable;
		logic [15:0] dac_code;
		logic        fault_flag;
		logic [1:0]  led_code;
	} out_item_t;

	typedef struct packed {
		logic        temperature_mode;
		logic        relay_enable;
		logic [15:0] relay_off_low;
		logic [15:0] relay_on_low;
		logic [15:0] relay_on_high;
		logic [15:0] relay_off_high;
		logic [15:0] range_low;
		logic [15:0] range_high;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic calc;
		logic mul;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_sts_t;

	function automatic logic signed [VAL_W-1:0] times_ten(input logic signed [15:0] x);
		logic signed [VAL_W-1:0] w;
		w = VAL_W'(x);
		return (w <<< 3) + (w <<< 1);
	endfunction

	function automatic logic [12:0] div_ten(input logic [15:0] r);
		logic [31:0] p;
		p = 32'(r) * 32'(RECIP_TEN);
		return p[31:RECIP_SHIFT];
	endfunction

endpackage
`default_nettype wire

/* src/srlo_cfg.sv */
// configuration register file of the relay and loop output core
// depends on srlo_pkg
`default_nettype none
module srlo_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [srlo_pkg::CFG_AW-1:0]  addr,
	input  wire logic [srlo_pkg::CFG_DW-1:0]  wdata,
	output srlo_pkg::cfg_t                    cfg
);
	import srlo_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(addr))
				REG_TEMPERATURE_MODE: cfg_q.temperature_mode <= wdata[0];
				REG_RELAY_ENABLE:     cfg_q.relay_enable     <= wdata[0];
				REG_RELAY_OFF_LOW:    cfg_q.relay_off_low    <= wdata;
				REG_RELAY_ON_LOW:     cfg_q.relay_on_low     <= wdata;
				REG_RELAY_ON_HIGH:    cfg_q.relay_on_high    <= wdata;
				REG_RELAY_OFF_HIGH:   cfg_q.relay_off_high   <= wdata;
				REG_RANGE_LOW:        cfg_q.range_low        <= wdata;
				REG_RANGE_HIGH:       cfg_q.range_high       <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* src/srlo_dp.sv */
// datapath: relay hysteresis, range check, span multiply, restoring divider, output register
// depends on srlo_pkg
`default_nettype none
module srlo_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srlo_pkg::cfg_t     cfg,
	input  wire srlo_pkg::dp_cmd_t  cmd,
	output srlo_pkg::dp_sts_t       sts,
	input  wire srlo_pkg::in_item_t in_data,
	output srlo_pkg::out_item_t     out_data
);
	import srlo_pkg::*;

	in_item_t            in_q;
	logic [12:0]         res10_q;
	logic                relay_q;
	logic [DIFF_W-1:0]   diff_q;
	logic [DIFF_W-1:0]   den_q;
	code_sel_t           sel_q;
	logic [DIFF_W-1:0]   rem_q;
	logic [Q_W-1:0]      quo_q;
	logic [CNT_W-1:0]    cnt_q;
	out_item_t           out_q;

	logic signed [VAL_W-1:0] cmp;
	logic signed [VAL_W-1:0] val;
	logic signed [VAL_W-1:0] lo;
	logic signed [VAL_W-1:0] hi;
	logic signed [VAL_W-1:0] diff;
	logic signed [VAL_W-1:0] den;
	logic                    on_band;
	logic                    release_hit;
	logic                    relay_d;
	logic                    active;
	logic                    empty;
	code_sel_t               sel_d;
	logic [PROD_W-1:0]       prod;
	logic [DIFF_W:0]         trial;
	logic                    ge;
	logic [DIFF_W:0]         rem_d;
	logic [15:0]             offset;
	logic [15:0]             span;
	logic [15:0]             code;
	logic [1:0]              led;

	assign active = (in_q.output_mode == MODE_VOLTAGE) || (in_q.output_mode == MODE_NAMUR);
	assign offset = (in_q.output_mode == MODE_NAMUR) ? NAMUR_OFFSET : VOLT_OFFSET;
	assign span   = (in_q.output_mode == MODE_NAMUR) ? NAMUR_SPAN : VOLT_SPAN;

	// relay compare
	always_comb begin
		cmp = cfg.temperature_mode ? VAL_W'($signed(in_q.temperature))
		                           : $signed(VAL_W'(in_q.resistance));
		on_band = (cmp >= times_ten(cfg.relay_on_low)) && (cmp <= times_ten(cfg.relay_on_high));
		release_hit = (cmp < times_ten(cfg.relay_off_low)) ||
		              (cmp >= times_ten(cfg.relay_off_high));
		relay_d = relay_q;
		if (on_band)
			relay_d = 1'b1;
		if (release_hit)
			relay_d = 1'b0;
		if (!cfg.relay_enable || in_q.link_fault)
			relay_d = 1'b0;
	end

	// output range classification
	always_comb begin
		if (cfg.temperature_mode) begin
			val = VAL_W'($signed(in_q.temperature));
			lo  = times_ten(cfg.range_low);
			hi  = times_ten(cfg.range_high);
		end else begin
			val = $signed(VAL_W'(res10_q));
			lo  = VAL_W'($signed(cfg.range_low));
			hi  = VAL_W'($signed(cfg.range_high));
		end
		diff  = val - lo;
		den   = hi - lo;
		empty = $signed(cfg.range_high) <= $signed(cfg.range_low);
		if (!active || in_q.link_fault)
			sel_d = SEL_ZERO;
		else if (val < lo)
			sel_d = SEL_ZERO;
		else if (val > hi)
			sel_d = SEL_FULL;
		else if (empty)
			sel_d = SEL_ZERO;
		else
			sel_d = SEL_SCALED;
	end

	assign prod  = PROD_W'(diff_q) * PROD_W'(span);
	assign trial = {rem_q, quo_q[Q_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_d = ge ? (trial - {1'b0, den_q}) : trial;

	always_comb begin
		case (sel_q)
			SEL_FULL:   code = CODE_FULL;
			SEL_SCALED: code = offset + quo_q;
			default:    code = '0;
		endcase
		if (in_q.link_fault)
			led = LED_FAULT;
		else if (in_q.resistance < SHORT_LIMIT)
			led = LED_SHORT;
		else if (in_q.resistance > OPEN_LIMIT)
			led = LED_OPEN;
		else
			led = LED_OFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cmd.calc)
				relay_q <= relay_d;
			if (cmd.mul)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q    <= in_data;
			res10_q <= div_ten(in_data.resistance);
		end
		if (cmd.calc) begin
			diff_q <= diff[DIFF_W-1:0];
			den_q  <= den[DIFF_W-1:0];
			sel_q  <= sel_d;
		end
		if (cmd.mul) begin
			rem_q <= prod[PROD_W-1:Q_W];
			quo_q <= prod[Q_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_d[DIFF_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
		if (cmd.load_out) begin
			out_q.relay_on   <= relay_q;
			out_q.dac_enable <= active;
			out_q.dac_code   <= code;
			out_q.fault_flag <= in_q.link_fault;
			out_q.led_code   <= led;
		end
	end

	assign sts.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign out_data     = out_q;

endmodule
`default_nettype wire

/* src/srlo_ctrl.sv */
// controller state machine: input handshake, step sequencing, output valid
// depends on srlo_pkg
`default_nettype none
module srlo_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire srlo_pkg::dp_sts_t sts,
	output srlo_pkg::dp_cmd_t      cmd
);
	import srlo_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* src/sensor_relay_and_loop_output_core.sv */
// top level of the transmitter relay and loop output core
// depends on srlo_pkg, srlo_cfg, srlo_ctrl, srlo_dp and the assertion macro header
//
// usage:
// - input channel in_valid/in_stall/in_data carries one sample transaction
//   (resistance, temperature, link fault, output mode); it is taken at a rising
//   edge with in_valid high and in_stall low
// - output channel out_valid/out_stall/out_data returns one result transaction
//   per sample: relay drive, dac enable, dac code, fault copy and led code
// - configuration is written through cfg_wr_en/cfg_addr/cfg_wdata, one register
//   per edge; the user must write it only while no sample is in flight, as the
//   block does not enforce this
// - each sample passes the calc and multiply steps, the 16-step restoring divider
//   that scales the dac span and the final step before a new sample is taken
// - the output register frees the datapath: a new sample may be taken while
//   a result still waits; if the receiver stalls, the next result waits
//   in the final step and in_stall stays high until it is handed over
// - reset clears all configuration registers to zero and the relay to off
`default_nettype none
`include "sensor_relay_and_loop_output_core_assert.svh"
module sensor_relay_and_loop_output_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire srlo_pkg::in_item_t           in_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output srlo_pkg::out_item_t               out_data,
	input  wire logic                         cfg_wr_en,
	input  wire logic [srlo_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [srlo_pkg::CFG_DW-1:0]  cfg_wdata
);
	import srlo_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	srlo_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	srlo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	srlo_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_data (out_data)
	);

	`SRLO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`SRLO_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.load_out, !(out_valid && out_stall))
	`SRLO_ASSERT_IMPLY(a_fault_relay_off, clk, arst_n, out_valid && out_data.fault_flag, !out_data.relay_on)
	`SRLO_ASSERT_IMPLY(a_off_code_zero, clk, arst_n, out_valid && !out_data.dac_enable, out_data.dac_code == 16'd0)

endmodule
`default_nettype wire

/* dv/sensor_relay_and_loop_output_core_test.sv */
// self-checking testbench of sensor_relay_and_loop_output_core: relay hysteresis,
// dac code scaling and led status checked against an in-bench predictor
// depends on srlo_pkg and the core; clocked driver and monitor, random idling
`timescale 1ns / 1ps
`default_nettype none
module sensor_relay_and_loop_output_core_test;
	import srlo_pkg::*;

	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         TENTHS      = 10;
	localparam int         RANDOM_PHASES = 12;
	localparam int         PHASE_ITEMS = 130;
	localparam int         SETTLE_CYCLES = 24;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         MAX_PRINTED = 100;

	logic      clk = 1'b1;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	in_item_t  pending_samples[$];
	out_item_t expected_results[$];
	cfg_t      shadow_cfg = '0;
	logic      relay_latch = 1'b0;
	bit        in_fire;
	bit        out_fire;
	bit        hold_off;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        error_count;
	int        idle_cycles;
	out_item_t want_result;

	sensor_relay_and_loop_output_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b0;
		#1 clk = 1'b1;
	end

	function automatic out_item_t predict_result(in_item_t s);
		int cmp, v, lo, hi, rlo, rhi;
		longint num, span;
		logic [15:0] offset, code;
		logic active;
		out_item_t r;
		rlo = int'($signed(shadow_cfg.range_low));
		rhi = int'($signed(shadow_cfg.range_high));
		if (shadow_cfg.temperature_mode)
			cmp = int'($signed(s.temperature));
		else
			cmp = int'(s.resistance);
		if (cmp >= int'($signed(shadow_cfg.relay_on_low)) * TENTHS &&
				cmp <= int'($signed(shadow_cfg.relay_on_high)) * TENTHS)
			relay_latch = 1'b1;
		if (cmp < int'($signed(shadow_cfg.relay_off_low)) * TENTHS ||
				cmp >= int'($signed(shadow_cfg.relay_off_high)) * TENTHS)
			relay_latch = 1'b0;
		if (!shadow_cfg.relay_enable || s.link_fault)
			relay_latch = 1'b0;
		active = (s.output_mode == MODE_VOLTAGE) || (s.output_mode == MODE_NAMUR);
		code = '0;
		if (active && !s.link_fault) begin
			if (shadow_cfg.temperature_mode) begin
				v = int'($signed(s.temperature));
				lo = rlo * TENTHS;
				hi = rhi * TENTHS;
			end else begin
				v = int'(s.resistance) / TENTHS;
				lo = rlo;
				hi = rhi;
			end
			if (v < lo)
				code = '0;
			else if (v > hi)
				code = CODE_FULL;
			else if (rhi <= rlo)
				code = '0;
			else begin
				span = (s.output_mode == MODE_NAMUR) ? longint'(NAMUR_SPAN) : longint'(VOLT_SPAN);
				offset = (s.output_mode == MODE_NAMUR) ? NAMUR_OFFSET : VOLT_OFFSET;
				num = longint'(v - lo) * span;
				code = 16'(longint'(offset) + num / longint'(hi - lo));
			end
		end
		r.relay_on = relay_latch;
		r.dac_enable = active;
		r.dac_code = code;
		r.fault_flag = s.link_fault;
		if (s.link_fault)
			r.led_code = LED_FAULT;
		else if (s.resistance < SHORT_LIMIT)
			r.led_code = LED_SHORT;
		else if (s.resistance > OPEN_LIMIT)
			r.led_code = LED_OPEN;
		else
			r.led_code = LED_OFF;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic cfg_t make_config(logic tm, logic en, int ol, int onl, int onh, int oh,
			int rl, int rh);
		cfg_t c;
		c.temperature_mode = tm;
		c.relay_enable = en;
		c.relay_off_low = 16'(ol);
		c.relay_on_low = 16'(onl);
		c.relay_on_high = 16'(onh);
		c.relay_off_high = 16'(oh);
		c.range_low = 16'(rl);
		c.range_high = 16'(rh);
		return c;
	endfunction

	function automatic int pick_extreme();
		int v;
		case ($urandom_range(3))
			0: v = -32768;
			1: v = 32767;
			2: v = 0;
			default: v = -1;
		endcase
		return v;
	endfunction

	function automatic cfg_t random_config(int kind);
		int b, onl, onh, oh;
		logic tm;
		tm = 1'($urandom_range(1));
		if (kind % 4 == 0)
			return make_config(tm, 1'($urandom_range(1)), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535), $urandom_range(65535));
		if (kind % 4 == 3)
			return make_config(tm, 1'b1, pick_extreme(), pick_extreme(), pick_extreme(),
				pick_extreme(), pick_extreme(), pick_extreme());
		b = tm ? int'($urandom_range(6000)) - 3000 : int'($urandom_range(6000));
		onl = b + int'($urandom_range(30));
		onh = onl + int'($urandom_range(30));
		oh = onh + int'($urandom_range(30));
		// overlapping release band now and then
		if ($urandom_range(4) == 0)
			oh = onl + int'($urandom_range(10));
		return make_config(tm, $urandom_range(9) != 0, b, onl, onh, oh,
			b - int'($urandom_range(200)), b + int'($urandom_range(300)) - 50);
	endfunction

	function automatic logic [15:0] clamp16(int v, int lo, int hi);
		if (v < lo)
			return 16'(lo);
		if (v > hi)
			return 16'(hi);
		return 16'(v);
	endfunction

	function automatic in_item_t random_sample();
		in_item_t s;
		int a, p;
		s.link_fault = ($urandom_range(11) == 0);
		case ($urandom_range(9))
			0: s.output_mode = MODE_OFF;
			1: s.output_mode = MODE_UNUSED;
			2, 3, 4, 5: s.output_mode = MODE_VOLTAGE;
			default: s.output_mode = MODE_NAMUR;
		endcase
		s.resistance = 16'($urandom_range(65535));
		s.temperature = 16'($urandom_range(65535));
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(5))
				0: a = int'($signed(shadow_cfg.relay_off_low));
				1: a = int'($signed(shadow_cfg.relay_on_low));
				2: a = int'($signed(shadow_cfg.relay_on_high));
				3: a = int'($signed(shadow_cfg.relay_off_high));
				4: a = int'($signed(shadow_cfg.range_low));
				default: a = int'($signed(shadow_cfg.range_high));
			endcase
			p = a * TENTHS + int'($urandom_range(80)) - 40;
			if (shadow_cfg.temperature_mode) begin
				s.temperature = clamp16(p, -32768, 32767);
				if ($urandom_range(3) == 0)
					s.resistance = 16'(($urandom_range(1) ? int'(SHORT_LIMIT) : int'(OPEN_LIMIT))
						+ int'($urandom_range(4)) - 2);
			end else
				s.resistance = clamp16(p, 0, 65535);
		end
		return s;
	endfunction

	task automatic add_sample(logic [15:0] r, logic [15:0] t, logic f, logic [1:0] m);
		in_item_t s;
		s.resistance = r;
		s.temperature = t;
		s.link_fault = f;
		s.output_mode = m;
		pending_samples.push_back(s);
	endtask

	task automatic apply_config(cfg_t c);
		logic [15:0] vals [8];
		vals[REG_TEMPERATURE_MODE] = 16'(c.temperature_mode);
		vals[REG_RELAY_ENABLE] = 16'(c.relay_enable);
		vals[REG_RELAY_OFF_LOW] = c.relay_off_low;
		vals[REG_RELAY_ON_LOW] = c.relay_on_low;
		vals[REG_RELAY_ON_HIGH] = c.relay_on_high;
		vals[REG_RELAY_OFF_HIGH] = c.relay_off_high;
		vals[REG_RANGE_LOW] = c.range_low;
		vals[REG_RANGE_HIGH] = c.range_high;
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_addr <= cfg_reg_t'(i);
			cfg_wdata <= vals[i];
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		shadow_cfg = c;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: a new transaction only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_samples.size() != 0 && !hold_off &&
					int'($urandom_range(99)) >= send_idle_pct) begin
				in_data <= pending_samples.pop_front();
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	always @(negedge clk)
		out_stall <= (int'($urandom_range(99)) < recv_idle_pct);

	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		out_fire = arst_n && out_valid && !out_stall;
		if (in_fire)
			expected_results.push_back(predict_result(in_data));
		if (out_fire) begin
			if (expected_results.size() == 0)
				report_mismatch("result transaction with nothing expected");
			else begin
				want_result = expected_results.pop_front();
				check_field("relay_on", 16'(out_data.relay_on), 16'(want_result.relay_on));
				check_field("dac_enable", 16'(out_data.dac_enable), 16'(want_result.dac_enable));
				check_field("dac_code", out_data.dac_code, want_result.dac_code);
				check_field("fault_flag", 16'(out_data.fault_flag), 16'(want_result.fault_flag));
				check_field("led_code", 16'(out_data.led_code), 16'(want_result.led_code));
			end
		end
		if (in_fire || out_fire || cfg_wr_en)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sensor_relay_and_loop_output_core verification failed");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		send_idle_pct = 35;
		recv_idle_pct = 52;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// resistance mode, band 1000..4000 tenths, output range 0..5000
		apply_config(make_config(1'b0, 1'b1, 100, 200, 300, 400, 0, 5000));
		add_sample(16'd0, 16'd0, 1'b0, MODE_VOLTAGE);
		add_sample(SHORT_LIMIT, 16'd0, 1'b0, MODE_VOLTAGE);
		add_sample(16'd2000, 16'h7FFF, 1'b0, MODE_VOLTAGE);
		add_sample(16'd3000, 16'h8000, 1'b0, MODE_NAMUR);
		add_sample(16'd3500, 16'hFFFF, 1'b0, MODE_VOLTAGE);
		add_sample(16'd4000, 16'd0, 1'b0, MODE_VOLTAGE);
		add_sample(16'd2500, 16'd0, 1'b0, MODE_NAMUR);
		add_sample(16'd1000, 16'd0, 1'b0, MODE_VOLTAGE);
		add_sample(16'd999, 16'd0, 1'b0, MODE_VOLTAGE);
		add_sample(OPEN_LIMIT, 16'd0, 1'b0, MODE_NAMUR);
		add_sample(OPEN_LIMIT + 16'd1, 16'd0, 1'b0, MODE_NAMUR);
		add_sample(16'd50010, 16'd0, 1'b0, MODE_VOLTAGE);
		add_sample(16'hFFFF, 16'd0, 1'b0, MODE_VOLTAGE);
		add_sample(16'd2500, 16'd0, 1'b0, MODE_OFF);
		add_sample(16'd2500, 16'd0, 1'b0, MODE_UNUSED);
		add_sample(16'd2500, 16'd0, 1'b1, MODE_NAMUR);
		drain();

		// temperature mode, every limit at the edge of its range
		apply_config(make_config(1'b1, 1'b1, -32768, -32768, 32767, 32767, -32768, 32767));
		add_sample(16'd500, 16'h8000, 1'b0, MODE_VOLTAGE);
		add_sample(16'd500, 16'h7FFF, 1'b0, MODE_NAMUR);
		add_sample(16'd500, 16'hFFFF, 1'b0, MODE_NAMUR);
		drain();

		// empty output range, on band overlapping the release limit
		apply_config(make_config(1'b1, 1'b1, -5, 0, 10, 5, 5, 5));
		add_sample(16'd500, 16'd40, 1'b0, MODE_VOLTAGE);
		add_sample(16'd500, 16'd60, 1'b0, MODE_VOLTAGE);
		add_sample(16'd500, 16'd50, 1'b0, MODE_VOLTAGE);
		add_sample(16'd500, 16'd49, 1'b0, MODE_NAMUR);
		add_sample(16'd500, 16'd51, 1'b0, MODE_NAMUR);
		drain();

		// relay disabled inside the on band
		apply_config(make_config(1'b0, 1'b0, 100, 200, 300, 400, 0, 5000));
		add_sample(16'd2500, 16'd0, 1'b0, MODE_VOLTAGE);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 35;
			end else if (p == 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			c = random_config(p);
			apply_config(c);
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_samples.push_back(random_sample());
			if (p % 3 == 1) begin
				while (pending_samples.size() > PHASE_ITEMS / 2)
					@(posedge clk);
				hold_off = 1'b1;
				while (in_valid || expected_results.size() != 0)
					@(posedge clk);
				hold_off = 1'b0;
			end
			drain();
		end

		if (error_count == 0)
			$display("sensor_relay_and_loop_output_core verification clean");
		else
			$display("sensor_relay_and_loop_output_core verification failed");
		$finish;
	end

endmodule
`default_nettype wire
